[hdl/mfrnt_pkg.sv]
`timescale 1ns / 1ps

package mfrnt_pkg;

    // Frame layout and limits
    localparam int PAYLOAD_MAX = 64;
    localparam int MIN_FRAME   = 5;
    localparam int INDEX_MAX   = 511;

    localparam logic [7:0] TYPE_HEARTBEAT = 8'h01;
    localparam logic [7:0] TYPE_DETECTION = 8'h02;
    localparam logic [7:0] TYPE_ACK       = 8'h03;

    // Configuration register indexes
    localparam logic CFG_OWN_NODE_ID    = 1'b0;
    localparam logic CFG_NODE_TIMEOUT   = 1'b1;
    localparam logic [15:0] TIMEOUT_RST = 16'd30;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_SWEEP = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAT_BYTE     = 3'd0,
        STAT_USED     = 3'd1,
        STAT_OWN      = 3'd2,
        STAT_SHORT    = 3'd3,
        STAT_OVERSIZE = 3'd4,
        STAT_TICK     = 3'd5,
        STAT_SWEEP    = 3'd6
    } status_t;

    // Outcome of the byte being taken, valid when status is STAT_USED
    typedef struct packed {
        status_t    status;
        logic [7:0] src;
        logic       is_det;
        logic       det;
        logic       chk_bad;
        logic       unknown;
    } frame_info_t;

    typedef struct packed {
        logic frame_go;
        logic sweep_go;
        logic tick;
    } tbl_cmd_t;

    typedef struct packed {
        status_t    status;
        logic       checksum_bad;
        logic       unknown_type;
        logic       detection_event;
        logic [7:0] event_node;
        logic       event_detecting;
        logic [8:0] evicted_count;
        logic [8:0] active_count;
        logic [8:0] detecting_count;
    } result_t;

endpackage

[hdl/mfrnt_frame_rx.sv]
`timescale 1ns / 1ps

module mfrnt_frame_rx #(
    parameter int PAYLOAD_MAX = mfrnt_pkg::PAYLOAD_MAX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_we,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_end,
    input  logic [7:0]            own_node_id,
    output mfrnt_pkg::frame_info_t info
);

    logic [8:0] idx_reg,   idx_next;
    logic [7:0] type_reg,  type_next;
    logic [7:0] src_reg,   src_next;
    logic [7:0] len_reg,   len_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] xor_reg,   xor_next;
    logic [7:0] chk_reg,   chk_next;
    logic [8:0] body;

    // Byte intake
    always_comb
    begin
        body       = 9'd4 + {1'b0, len_reg};
        type_next  = (idx_reg == 9'd0) ? rx_byte : type_reg;
        src_next   = (idx_reg == 9'd1) ? rx_byte : src_reg;
        len_next   = (idx_reg == 9'd3) ? rx_byte : len_reg;
        first_next = (idx_reg == 9'd4 && len_reg != 8'd0) ? rx_byte : first_reg;
        xor_next   = xor_reg;
        chk_next   = chk_reg;
        if (idx_reg < 9'd4 || idx_reg < body)
        begin
            xor_next = xor_reg ^ rx_byte;
        end
        else if (idx_reg == body)
        begin
            chk_next = rx_byte;
        end
        idx_next = (idx_reg < 9'(mfrnt_pkg::INDEX_MAX)) ? idx_reg + 9'd1 : idx_reg;
    end

    // Frame checks on the post-intake values
    always_comb
    begin
        info.src     = src_next;
        info.is_det  = (type_next == mfrnt_pkg::TYPE_DETECTION);
        info.det     = (len_next != 8'd0) && (first_next == 8'd1);
        info.chk_bad = (chk_next != xor_next);
        info.unknown = (type_next != mfrnt_pkg::TYPE_HEARTBEAT)
                    && (type_next != mfrnt_pkg::TYPE_DETECTION)
                    && (type_next != mfrnt_pkg::TYPE_ACK);
        if (!frame_end)
        begin
            info.status = mfrnt_pkg::STAT_BYTE;
        end
        else if (idx_next < 9'(mfrnt_pkg::MIN_FRAME))
        begin
            info.status = mfrnt_pkg::STAT_SHORT;
        end
        else if (len_next > 8'(PAYLOAD_MAX))
        begin
            info.status = mfrnt_pkg::STAT_OVERSIZE;
        end
        else if (idx_next < 9'(mfrnt_pkg::MIN_FRAME) + {1'b0, len_next})
        begin
            info.status = mfrnt_pkg::STAT_SHORT;
        end
        else if (src_next == own_node_id)
        begin
            info.status = mfrnt_pkg::STAT_OWN;
        end
        else
        begin
            info.status = mfrnt_pkg::STAT_USED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            type_reg  <= '0;
            src_reg   <= '0;
            len_reg   <= '0;
            first_reg <= '0;
            xor_reg   <= '0;
            chk_reg   <= '0;
        end
        else if (byte_we)
        begin
            if (frame_end)
            begin
                idx_reg   <= '0;
                type_reg  <= '0;
                src_reg   <= '0;
                len_reg   <= '0;
                first_reg <= '0;
                xor_reg   <= '0;
                chk_reg   <= '0;
            end
            else
            begin
                idx_reg   <= idx_next;
                type_reg  <= type_next;
                src_reg   <= src_next;
                len_reg   <= len_next;
                first_reg <= first_next;
                xor_reg   <= xor_next;
                chk_reg   <= chk_next;
            end
        end
    end

endmodule

[hdl/mfrnt_node_table.sv]
`timescale 1ns / 1ps

module mfrnt_node_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mfrnt_pkg::tbl_cmd_t    cmd,
    input  mfrnt_pkg::frame_info_t finfo,
    input  logic [15:0]            timeout,
    output logic                   busy,
    output logic                   done,
    output mfrnt_pkg::result_t     done_res,
    output logic [8:0]             active_count,
    output logic [8:0]             detecting_count
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_SWEEP  = 3'b100
    } tbl_state_t;

    tbl_state_t state_reg, state_next;

    // Entry: {detect flag, last seen time}; meaningful only where valid is set
    logic [32:0]  slot_mem [256];
    logic [32:0]  rd_data_reg;
    logic [7:0]   rd_addr;
    logic         mem_we;
    logic [32:0]  wr_data;

    logic [255:0] valid_reg;
    logic [31:0]  now_reg;
    logic [8:0]   active_reg,   active_next;
    logic [8:0]   det_cnt_reg,  det_cnt_next;
    logic [8:0]   evicted_reg;
    logic [8:0]   sweep_k_reg;
    logic         eval_reg;
    logic [7:0]   eval_addr_reg;

    mfrnt_pkg::frame_info_t upd_reg;

    logic        was_valid;
    logic        old_det;
    logic        det_new;
    logic [31:0] age;
    logic        evict;
    logic        sweep_end;

    assign busy            = (state_reg != ST_IDLE);
    assign active_count    = active_reg;
    assign detecting_count = det_cnt_reg;

    assign rd_addr = (state_reg == ST_SWEEP) ? sweep_k_reg[7:0] : finfo.src;

    assign was_valid = valid_reg[upd_reg.src];
    assign old_det   = was_valid & rd_data_reg[32];
    assign det_new   = upd_reg.is_det ? upd_reg.det : old_det;
    assign mem_we    = (state_reg == ST_UPDATE);
    assign wr_data   = {det_new, now_reg};

    assign age       = now_reg - rd_data_reg[31:0];
    assign evict     = (state_reg == ST_SWEEP) && eval_reg && valid_reg[eval_addr_reg]
                    && (age > {16'd0, timeout});
    assign sweep_end = (state_reg == ST_SWEEP) && sweep_k_reg[8] && !eval_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[upd_reg.src] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_comb
    begin
        active_next  = active_reg;
        det_cnt_next = det_cnt_reg;
        if (state_reg == ST_UPDATE)
        begin
            if (!was_valid)
            begin
                active_next = active_reg + 9'd1;
            end
            if (upd_reg.is_det && upd_reg.det && !old_det)
            begin
                det_cnt_next = det_cnt_reg + 9'd1;
            end
            else if (upd_reg.is_det && !upd_reg.det && old_det)
            begin
                det_cnt_next = det_cnt_reg - 9'd1;
            end
        end
        else if (evict)
        begin
            active_next = active_reg - 9'd1;
            if (rd_data_reg[32])
            begin
                det_cnt_next = det_cnt_reg - 9'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.frame_go)
                begin
                    state_next = ST_UPDATE;
                end
                else if (cmd.sweep_go)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done     = mem_we || sweep_end;
        done_res = '0;
        done_res.active_count    = active_next;
        done_res.detecting_count = det_cnt_next;
        if (sweep_end)
        begin
            done_res.status        = mfrnt_pkg::STAT_SWEEP;
            done_res.evicted_count = evicted_reg;
        end
        else
        begin
            done_res.status          = mfrnt_pkg::STAT_USED;
            done_res.checksum_bad    = upd_reg.chk_bad;
            done_res.unknown_type    = upd_reg.unknown;
            done_res.detection_event = upd_reg.is_det;
            done_res.event_node      = upd_reg.src;
            done_res.event_detecting = upd_reg.is_det & upd_reg.det;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            now_reg       <= '0;
            active_reg    <= '0;
            det_cnt_reg   <= '0;
            evicted_reg   <= '0;
            sweep_k_reg   <= '0;
            eval_reg      <= 1'b0;
            eval_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            det_cnt_reg <= det_cnt_next;
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
            end
            if (mem_we)
            begin
                valid_reg[upd_reg.src] <= 1'b1;
            end
            if (evict)
            begin
                valid_reg[eval_addr_reg] <= 1'b0;
                evicted_reg              <= evicted_reg + 9'd1;
            end
            if (state_reg == ST_IDLE && cmd.sweep_go)
            begin
                sweep_k_reg <= '0;
                eval_reg    <= 1'b0;
                evicted_reg <= '0;
            end
            else if (state_reg == ST_SWEEP)
            begin
                eval_reg      <= !sweep_k_reg[8];
                eval_addr_reg <= sweep_k_reg[7:0];
                if (!sweep_k_reg[8])
                begin
                    sweep_k_reg <= sweep_k_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd.frame_go)
        begin
            upd_reg <= finfo;
        end
    end

endmodule

[hdl/mesh_frame_receiver_node_table_top.sv]
`timescale 1ns / 1ps

// Mesh frame receiver with a 256-entry node table.
// Input channel (in_valid / in_stall): op selects a received byte, a time
// tick or a sweep of stale nodes; rx_byte and frame_end go with a byte.
// Output channel (out_valid / out_stall): one result transaction per input
// transaction, in order, carrying status, event fields and node counts.
// Config port: cfg_we writes cfg_data into own_node_id (index 0) or
// node_timeout_ticks (index 1); write only while the block is idle.
// Order: a byte, tick or dropped/ignored frame end has its result registered
// at acceptance; a used frame end first reads the node memory, then writes it
// back and registers its result; a sweep does one node memory read per entry,
// then drains the pipeline before its result is registered.
// Throughput: bytes are taken one per cycle unless input is stalled; the memory
// read-modify-write of a used frame and the 256-entry sweep hold off new input
// while they run. A finished result waits in the output register; a second
// one parks in a hold register, and input also stalls once that is occupied.
// Reset clears frame state, the clock, the counts and all valid bits at once;
// no clearing pass is needed and input is taken right after reset.

module mesh_frame_receiver_node_table_top #(
    parameter int PAYLOAD_MAX = mfrnt_pkg::PAYLOAD_MAX
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        checksum_bad,
    output logic        unknown_type,
    output logic        detection_event,
    output logic [7:0]  event_node,
    output logic        event_detecting,
    output logic [8:0]  evicted_count,
    output logic [8:0]  active_count,
    output logic [8:0]  detecting_count,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  own_id_reg;
    logic [15:0] timeout_reg;

    logic accept;
    logic byte_we;
    logic imm_done;
    logic tbl_busy;
    logic tbl_done;
    logic [8:0] tbl_active;
    logic [8:0] tbl_detecting;

    mfrnt_pkg::frame_info_t finfo;
    mfrnt_pkg::tbl_cmd_t    cmd;
    mfrnt_pkg::result_t     tbl_res;
    mfrnt_pkg::result_t     imm_res;
    mfrnt_pkg::result_t     res;

    // Output register plus one hold slot
    mfrnt_pkg::result_t out_reg;
    mfrnt_pkg::result_t hold_reg;
    logic out_valid_reg;
    logic hold_valid_reg;
    logic load_out;

    assign in_stall = tbl_busy || hold_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign byte_we  = accept && (mfrnt_pkg::op_t'(op) == mfrnt_pkg::OP_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg  <= '0;
            timeout_reg <= mfrnt_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mfrnt_pkg::CFG_OWN_NODE_ID)
            begin
                own_id_reg <= cfg_data[7:0];
            end
            else
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    mfrnt_frame_rx #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_frame_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_we     (byte_we),
        .rx_byte     (rx_byte),
        .frame_end   (frame_end),
        .own_node_id (own_id_reg),
        .info        (finfo)
    );

    mfrnt_node_table u_node_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .finfo           (finfo),
        .timeout         (timeout_reg),
        .busy            (tbl_busy),
        .done            (tbl_done),
        .done_res        (tbl_res),
        .active_count    (tbl_active),
        .detecting_count (tbl_detecting)
    );

    // Decode an accepted transaction: start table work, answer now, or both for a tick
    always_comb
    begin
        cmd      = '0;
        imm_done = 1'b0;
        imm_res  = '0;
        imm_res.active_count    = tbl_active;
        imm_res.detecting_count = tbl_detecting;
        case (mfrnt_pkg::op_t'(op))
            mfrnt_pkg::OP_BYTE:
            begin
                if (finfo.status == mfrnt_pkg::STAT_USED)
                begin
                    cmd.frame_go = accept;
                end
                else
                begin
                    imm_done       = accept;
                    imm_res.status = finfo.status;
                end
            end
            mfrnt_pkg::OP_TICK:
            begin
                cmd.tick       = accept;
                imm_done       = accept;
                imm_res.status = mfrnt_pkg::STAT_TICK;
            end
            mfrnt_pkg::OP_SWEEP:
            begin
                cmd.sweep_go = accept;
            end
            default:
            begin
                imm_done       = accept;
                imm_res.status = mfrnt_pkg::STAT_BYTE;
            end
        endcase
    end

    assign res      = tbl_done ? tbl_res : imm_res;
    assign load_out = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (hold_valid_reg)
        begin
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
        end
        else if (tbl_done || imm_done)
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                hold_valid_reg <= 1'b1;
            end
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_valid_reg)
        begin
            if (load_out)
            begin
                out_reg <= hold_reg;
            end
        end
        else if (tbl_done || imm_done)
        begin
            if (load_out)
            begin
                out_reg <= res;
            end
            else
            begin
                hold_reg <= res;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign checksum_bad    = out_reg.checksum_bad;
    assign unknown_type    = out_reg.unknown_type;
    assign detection_event = out_reg.detection_event;
    assign event_node      = out_reg.event_node;
    assign event_detecting = out_reg.event_detecting;
    assign evicted_count   = out_reg.evicted_count;
    assign active_count    = out_reg.active_count;
    assign detecting_count = out_reg.detecting_count;

endmodule

[bench/mesh_frame_receiver_node_table_top_tb.sv]
`timescale 1ns / 1ps

module mesh_frame_receiver_node_table_top_tb;

    // op 3 is not decoded by the block; it must leave everything alone
    localparam logic [1:0] OP_UNDEF      = 2'd3;
    // frame types outside heartbeat/detection/ack
    localparam logic [7:0] TYPE_NONE     = 8'h00;
    localparam logic [7:0] TYPE_RESERVED = 8'hFF;
    // a sweep walks all 256 entries, so give the tail plenty of room
    localparam int DRAIN_WAIT  = 300;
    localparam int MAX_REPORTS = 10;
    // entries filled before the evict-all sweep
    localparam int FILL_NODES  = 16;
    // random transactions per register setting
    localparam int PHASE_ITEMS = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = mfrnt_pkg::OP_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        checksum_bad;
    logic        unknown_type;
    logic        detection_event;
    logic [7:0]  event_node;
    logic        event_detecting;
    logic [8:0]  evicted_count;
    logic [8:0]  active_count;
    logic [8:0]  detecting_count;
    logic        cfg_we = 1'b0;
    logic        cfg_index = mfrnt_pkg::CFG_OWN_NODE_ID;
    logic [15:0] cfg_data = 16'h0000;

    // Idling controls, switched per test phase
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;
    int unsigned stall_left = 0;

    // Predictor state: frame assembly
    logic [8:0]  rx_count;
    logic [7:0]  hdr_kind;
    logic [7:0]  hdr_from;
    logic [7:0]  hdr_size;
    logic [7:0]  pay_first;
    logic [7:0]  xor_acc;
    logic [7:0]  chk_byte;
    // Predictor state: clock and node table
    logic [31:0] tick_count;
    logic        node_present [256];
    logic        node_alarm [256];
    logic [31:0] node_stamp [256];
    logic [8:0]  present_total;
    logic [8:0]  alarm_total;
    // Predictor copy of the registers
    logic [7:0]  my_node;
    logic [15:0] age_limit;

    // Outcomes predicted at input acceptance, consumed by the output monitor
    mfrnt_pkg::result_t pending_outcomes [$];
    mfrnt_pkg::result_t got;
    mfrnt_pkg::result_t want;

    int items_sent = 0;
    int fails = 0;
    // Tallies for the closing summary
    int n_used = 0;
    int n_own = 0;
    int n_short = 0;
    int n_oversize = 0;
    int n_det_events = 0;
    int n_sweeps = 0;
    int n_evicted = 0;
    int peak_nodes = 0;

    mesh_frame_receiver_node_table_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .rx_byte         (rx_byte),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .checksum_bad    (checksum_bad),
        .unknown_type    (unknown_type),
        .detection_event (detection_event),
        .event_node      (event_node),
        .event_detecting (event_detecting),
        .evicted_count   (evicted_count),
        .active_count    (active_count),
        .detecting_count (detecting_count),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // Safety net against a hung handshake
    initial
    begin
        #4_000_000;
        $display("Timeout: %0d outcomes still pending", pending_outcomes.size());
        $display("Verification failed");
        $finish;
    end

    // Receiver back-pressure: runs of stall or no stall, mostly short, a few long
    always @(posedge clk)
    begin
        if (!rst_n || !stall_on)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 99) < 35);
            stall_left <= ($urandom_range(0, 99) < 8) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
        end
    end

    // Expected outcome of one transaction; advances the predictor state.
    function automatic mfrnt_pkg::result_t receiver_outcome(input logic [1:0] item_op,
                                                            input logic [7:0] b,
                                                            input logic       fend);
        mfrnt_pkg::result_t res;
        int                 body;
        logic               det;
        logic [31:0]        age;
        int unsigned        evicted;
        int                 k;
        res = '0;
        case (item_op)
            mfrnt_pkg::OP_BYTE:
            begin
                // body is taken from the length seen so far, before this byte
                body = 4 + int'(hdr_size);
                if (rx_count == 0)
                    hdr_kind = b;
                else if (rx_count == 1)
                    hdr_from = b;
                else if (rx_count == 3)
                    hdr_size = b;
                if (rx_count == 4 && hdr_size != 0)
                    pay_first = b;
                if (rx_count < 4 || rx_count < body)
                    xor_acc = xor_acc ^ b;
                else if (rx_count == body)
                    chk_byte = b;
                // byte counter saturates on a long run
                if (rx_count < mfrnt_pkg::INDEX_MAX)
                    rx_count = rx_count + 9'd1;
                res.status = mfrnt_pkg::STAT_BYTE;
                if (fend)
                begin
                    if (rx_count < mfrnt_pkg::MIN_FRAME)
                    begin
                        res.status = mfrnt_pkg::STAT_SHORT;
                        n_short++;
                    end
                    else if (hdr_size > mfrnt_pkg::PAYLOAD_MAX)
                    begin
                        res.status = mfrnt_pkg::STAT_OVERSIZE;
                        n_oversize++;
                    end
                    else if (rx_count < mfrnt_pkg::MIN_FRAME + int'(hdr_size))
                    begin
                        res.status = mfrnt_pkg::STAT_SHORT;
                        n_short++;
                    end
                    else if (hdr_from == my_node)
                    begin
                        res.status = mfrnt_pkg::STAT_OWN;
                        n_own++;
                    end
                    else
                    begin
                        // new node enters with its detect flag clear
                        if (!node_present[hdr_from])
                        begin
                            node_present[hdr_from] = 1'b1;
                            node_alarm[hdr_from]   = 1'b0;
                            present_total          = present_total + 9'd1;
                        end
                        node_stamp[hdr_from] = tick_count;
                        res.status       = mfrnt_pkg::STAT_USED;
                        res.checksum_bad = (chk_byte != xor_acc);
                        res.event_node   = hdr_from;
                        n_used++;
                        if (hdr_kind == mfrnt_pkg::TYPE_DETECTION)
                        begin
                            // empty payload clears the flag
                            det = (hdr_size != 0) && (pay_first == 8'h01);
                            if (det && !node_alarm[hdr_from])
                                alarm_total = alarm_total + 9'd1;
                            if (!det && node_alarm[hdr_from])
                                alarm_total = alarm_total - 9'd1;
                            node_alarm[hdr_from]  = det;
                            res.detection_event   = 1'b1;
                            res.event_detecting   = det;
                            n_det_events++;
                        end
                        else if (hdr_kind != mfrnt_pkg::TYPE_HEARTBEAT
                                 && hdr_kind != mfrnt_pkg::TYPE_ACK)
                        begin
                            res.unknown_type = 1'b1;
                        end
                        if (int'(present_total) > peak_nodes)
                            peak_nodes = int'(present_total);
                    end
                    // frame state starts over after every frame end
                    rx_count  = '0;
                    hdr_kind  = '0;
                    hdr_from  = '0;
                    hdr_size  = '0;
                    pay_first = '0;
                    xor_acc   = '0;
                    chk_byte  = '0;
                end
            end
            mfrnt_pkg::OP_TICK:
            begin
                tick_count = tick_count + 32'd1;
                res.status = mfrnt_pkg::STAT_TICK;
            end
            mfrnt_pkg::OP_SWEEP:
            begin
                evicted = 0;
                for (k = 0; k < 256; k++)
                begin
                    age = tick_count - node_stamp[k];
                    if (node_present[k] && age > {16'd0, age_limit})
                    begin
                        if (node_alarm[k])
                            alarm_total = alarm_total - 9'd1;
                        node_present[k] = 1'b0;
                        node_alarm[k]   = 1'b0;
                        present_total   = present_total - 9'd1;
                        evicted++;
                    end
                end
                res.status        = mfrnt_pkg::STAT_SWEEP;
                res.evicted_count = evicted[8:0];
                n_sweeps++;
                n_evicted += int'(evicted);
            end
            default:
            begin
                res.status = mfrnt_pkg::STAT_BYTE;
            end
        endcase
        res.active_count    = present_total;
        res.detecting_count = alarm_total;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Mostly a small pool so nodes get refreshed; sometimes our own id
    function automatic logic [7:0] pick_src();
        int unsigned r;
        logic [7:0]  any;
        r   = $urandom_range(0, 99);
        any = 8'($urandom);
        if (r < 70)
            return 8'($urandom_range(0, 15));
        else if (r < 85)
            return my_node;
        else
            return any;
    endfunction

    // One input transaction; the outcome is predicted at the accepting edge
    task automatic send_item(input logic [1:0] item_op, input logic [7:0] item_byte,
                             input logic item_end);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= item_op;
        rx_byte   <= item_byte;
        frame_end <= item_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_outcomes.push_back(receiver_outcome(item_op, item_byte, item_end));
        items_sent++;
    endtask

    // Builds type, source, destination, length, payload, checksum, extra bytes;
    // keep > 0 cuts the frame to that many bytes.
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] src,
                              input logic [7:0] hdr_len, input int n_pay,
                              input logic [7:0] first, input bit bad_chk,
                              input int extra, input int keep);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        logic [7:0] rnd;
        int         k;
        int         last;
        rnd = 8'($urandom);
        bytes.push_back(ftype);
        bytes.push_back(src);
        bytes.push_back(rnd);
        bytes.push_back(hdr_len);
        for (k = 0; k < n_pay; k++)
        begin
            rnd = 8'($urandom);
            bytes.push_back((k == 0) ? first : rnd);
        end
        sum = '0;
        for (k = 0; k < bytes.size(); k++)
            sum = sum ^ bytes[k];
        if (bad_chk)
        begin
            rnd = 8'($urandom_range(1, 255));
            sum = sum ^ rnd;
        end
        bytes.push_back(sum);
        for (k = 0; k < extra; k++)
        begin
            rnd = 8'($urandom);
            bytes.push_back(rnd);
        end
        last = (keep > 0 && keep < bytes.size()) ? keep : bytes.size();
        for (k = 0; k < last; k++)
            send_item(mfrnt_pkg::OP_BYTE, bytes[k], k == last - 1);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == mfrnt_pkg::CFG_OWN_NODE_ID)
            my_node = data[7:0];
        else
            age_limit = data;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Upper byte is junk on purpose; only the low byte belongs to the register
    task automatic set_own_id(input logic [7:0] id);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(mfrnt_pkg::CFG_OWN_NODE_ID, {junk, id});
    endtask

    // Wait until every predicted outcome has come out, then let things settle
    task automatic drain_outcomes();
        in_valid <= 1'b0;
        while (pending_outcomes.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Reset values: empty table, default own id; a tick and a sweep on nothing
    task automatic test_reset_state();
        send_item(mfrnt_pkg::OP_TICK, 8'hFF, 1'b1);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        drain_outcomes();
    endtask

    // Every frame outcome and frame type, plus the undecoded op
    task automatic test_frame_kinds();
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd5, 8'd0, 0, 8'h00, 0, 0, 0);
        send_frame(mfrnt_pkg::TYPE_ACK, 8'd6, 8'd2, 2, 8'hA5, 0, 0, 0);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd7, 8'd1, 1, 8'h01, 0, 0, 0);
        // first payload byte other than one clears the flag
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd7, 8'd3, 3, 8'h81, 0, 0, 0);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd7, 8'd1, 1, 8'h01, 0, 0, 0);
        // empty detection payload clears the flag too
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd7, 8'd0, 0, 8'h00, 0, 0, 0);
        send_frame(TYPE_NONE, 8'd8, 8'd1, 1, 8'h55, 0, 0, 0);
        send_frame(TYPE_RESERVED, 8'd9, 8'd2, 2, 8'hFE, 1, 0, 0);
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd10, 8'd0, 0, 8'h00, 1, 0, 0);
        // frame from ourselves (own id still at reset value)
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, my_node, 8'd0, 0, 8'h00, 0, 0, 0);
        // short: single byte, header cut, payload shorter than its length
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd11, 8'd0, 0, 8'h00, 0, 0, 1);
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd11, 8'd0, 0, 8'h00, 0, 0, 4);
        send_frame(mfrnt_pkg::TYPE_ACK, 8'd11, 8'd4, 2, 8'h33, 0, 0, 0);
        // oversize: just past the limit and the largest length
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd12, 8'(mfrnt_pkg::PAYLOAD_MAX + 1), 0,
                   8'h00, 0, 0, 0);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd12, 8'hFF, 3, 8'h01, 0, 0, 0);
        // trailing bytes after the checksum are ignored
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd13, 8'd1, 1, 8'h77, 0, 3, 0);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd255, 8'(mfrnt_pkg::PAYLOAD_MAX),
                   mfrnt_pkg::PAYLOAD_MAX, 8'h01, 0, 0, 0);
        send_item(OP_UNDEF, 8'hFF, 1'b1);
        send_item(OP_UNDEF, 8'h00, 1'b0);
        drain_outcomes();
    endtask

    // Age boundary at the default timeout, then the zero and largest timeouts
    task automatic test_node_aging();
        repeat (30) send_item(mfrnt_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        drain_outcomes();
        write_reg(mfrnt_pkg::CFG_NODE_TIMEOUT, 16'h0000);
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd3, 8'd0, 0, 8'h00, 0, 0, 0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        drain_outcomes();
        write_reg(mfrnt_pkg::CFG_NODE_TIMEOUT, 16'hFFFF);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd4, 8'd1, 1, 8'h01, 0, 0, 0);
        repeat (12) send_item(mfrnt_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        drain_outcomes();
    endtask

    // Runs the byte counter into saturation inside one frame
    task automatic test_long_run();
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'h2A, 8'(mfrnt_pkg::PAYLOAD_MAX),
                   mfrnt_pkg::PAYLOAD_MAX, 8'h00, 0, 452, 0);
        drain_outcomes();
    endtask

    // Fill a block of entries, all detecting, then evict everything at once
    task automatic test_full_table();
        int n;
        set_own_id(8'd0);
        for (n = 1; n < FILL_NODES; n++)
            send_frame(mfrnt_pkg::TYPE_DETECTION, n[7:0], 8'd1, 1, 8'h01, 0, 0, 0);
        drain_outcomes();
        // node 0 only becomes eligible once it is no longer our own id
        set_own_id(8'd1);
        send_frame(mfrnt_pkg::TYPE_DETECTION, 8'd0, 8'd1, 1, 8'h01, 0, 0, 0);
        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, 8'd5, 8'd0, 0, 8'h00, 0, 0, 0);
        drain_outcomes();
        write_reg(mfrnt_pkg::CFG_NODE_TIMEOUT, 16'h0000);
        send_item(mfrnt_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(mfrnt_pkg::OP_SWEEP, 8'h00, 1'b0);
        drain_outcomes();
    endtask

    // Mostly well-formed frames with random content, mixed with ticks, sweeps,
    // broken frames and noise; four register settings, one with no idling
    task automatic test_random_traffic();
        int          phase;
        int          target;
        int unsigned r;
        int unsigned k;
        int          n_pay;
        int          hl;
        logic [7:0]  ftype;
        logic [7:0]  rnd8;
        logic [15:0] lim;
        for (phase = 0; phase < 4; phase++)
        begin
            drain_outcomes();
            gaps_on  = (phase != 1);
            stall_on = (phase != 1);
            set_own_id(pick_src());
            case (phase)
                0: lim = 16'($urandom_range(0, 8));
                1: lim = 16'($urandom_range(5, 40));
                2: lim = 16'hFFFF;
                default: lim = 16'($urandom_range(0, 65535));
            endcase
            write_reg(mfrnt_pkg::CFG_NODE_TIMEOUT, lim);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                r    = $urandom_range(0, 99);
                rnd8 = 8'($urandom);
                if (r < 65)
                begin
                    k = $urandom_range(0, 99);
                    ftype = (k < 35) ? mfrnt_pkg::TYPE_HEARTBEAT :
                            (k < 70) ? mfrnt_pkg::TYPE_DETECTION :
                            (k < 85) ? mfrnt_pkg::TYPE_ACK : rnd8;
                    k = $urandom_range(0, 99);
                    n_pay = (k < 80) ? int'($urandom_range(0, 4)) :
                            (k < 95) ? int'($urandom_range(5, 16)) :
                                       int'($urandom_range(17, mfrnt_pkg::PAYLOAD_MAX));
                    rnd8 = 8'($urandom);
                    send_frame(ftype, pick_src(), n_pay[7:0], n_pay,
                               ($urandom_range(0, 1) == 1) ? 8'h01 : rnd8,
                               $urandom_range(0, 9) == 0,
                               ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 3)) : 0,
                               0);
                end
                else if (r < 75)
                begin
                    k     = $urandom_range(0, 2);
                    n_pay = int'($urandom_range(0, 6));
                    if (k == 0)
                    begin
                        send_frame(rnd8, pick_src(), n_pay[7:0], n_pay, rnd8, 0, 0,
                                   int'($urandom_range(1, 4)));
                    end
                    else if (k == 1)
                    begin
                        hl = n_pay + int'($urandom_range(1, 8));
                        send_frame(mfrnt_pkg::TYPE_DETECTION, pick_src(), hl[7:0], n_pay,
                                   8'h01, 0, 0, 0);
                    end
                    else
                    begin
                        hl    = int'($urandom_range(mfrnt_pkg::PAYLOAD_MAX + 1, 255));
                        n_pay = int'($urandom_range(0, 3));
                        send_frame(mfrnt_pkg::TYPE_HEARTBEAT, pick_src(), hl[7:0], n_pay,
                                   rnd8, 0, 0, 0);
                    end
                end
                else if (r < 88)
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(mfrnt_pkg::OP_TICK, 8'($urandom),
                                  1'($urandom_range(0, 1)));
                end
                else if (r < 93)
                begin
                    send_item(mfrnt_pkg::OP_SWEEP, 8'($urandom), 1'($urandom_range(0, 1)));
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    send_item(OP_UNDEF, 8'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    // stray byte that ends up in front of the next frame
                    send_item(mfrnt_pkg::OP_BYTE, 8'($urandom), 1'b0);
                end
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        drain_outcomes();
    endtask

    // Output monitor: each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, checksum_bad, unknown_type, detection_event, event_node,
                   event_detecting, evicted_count, active_count, detecting_count};
            if (pending_outcomes.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("%0t: result transaction with nothing expected, status %0d",
                             $realtime, status);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got !== want)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display({"%0t: mismatch exp/got status %0d/%0d chk %0b/%0b ",
                                  "unk %0b/%0b det_ev %0b/%0b node %0d/%0d det %0b/%0b ",
                                  "evicted %0d/%0d active %0d/%0d detecting %0d/%0d"},
                                 $realtime, want.status, got.status,
                                 want.checksum_bad, got.checksum_bad,
                                 want.unknown_type, got.unknown_type,
                                 want.detection_event, got.detection_event,
                                 want.event_node, got.event_node,
                                 want.event_detecting, got.event_detecting,
                                 want.evicted_count, got.evicted_count,
                                 want.active_count, got.active_count,
                                 want.detecting_count, got.detecting_count);
                end
            end
        end
    end

    initial
    begin
        int k;
        // predictor starts from the reset state
        rx_count      = '0;
        hdr_kind      = '0;
        hdr_from      = '0;
        hdr_size      = '0;
        pay_first     = '0;
        xor_acc       = '0;
        chk_byte      = '0;
        tick_count    = '0;
        present_total = '0;
        alarm_total   = '0;
        my_node       = '0;
        age_limit     = mfrnt_pkg::TIMEOUT_RST;
        for (k = 0; k < 256; k++)
        begin
            node_present[k] = 1'b0;
            node_alarm[k]   = 1'b0;
            node_stamp[k]   = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_frame_kinds();
        test_node_aging();
        test_long_run();
        test_full_table();
        test_random_traffic();

        drain_outcomes();
        // catch any result that shows up late with nothing expected
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            fails++;
            $display("%0d predicted results never arrived", pending_outcomes.size());
        end
        $display("Sent %0d transactions: %0d frames used, %0d own, %0d short, %0d oversize",
                 items_sent, n_used, n_own, n_short, n_oversize);
        $display("%0d detection events, %0d sweeps evicting %0d nodes, peak table %0d",
                 n_det_events, n_sweeps, n_evicted, peak_nodes);
        $display("%0d errors", fails);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/mfrnt_pkg.sv
hdl/mfrnt_frame_rx.sv
hdl/mfrnt_node_table.sv
hdl/mesh_frame_receiver_node_table_top.sv
bench/mesh_frame_receiver_node_table_top_tb.sv
